// File: hdl/pef3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pef3_pkg;

  localparam int unsigned IMAGE_SIZE = 512;
  localparam int unsigned POS_W      = $clog2(IMAGE_SIZE);
  localparam int unsigned PIX_W      = 8;
  // three pixels summed, and the magnitude of a difference of two such sums
  localparam int unsigned SUM_W      = PIX_W + 2;

  // floor(m / 3) == (m * DIV3_MUL) >> DIV3_SHIFT for every m below 2048
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned DIV3_MUL   = 683;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam pos_t POS_LAST = pos_t'(IMAGE_SIZE - 1);

  function automatic pixel_t div3(input sum_t m);
    logic [SUM_W+DIV3_SHIFT-1:0] prod;
    prod = {{DIV3_SHIFT{1'b0}}, m} * (SUM_W + DIV3_SHIFT)'(DIV3_MUL);
    return prod[DIV3_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

// File: hdl/prewitt_edge_filter_3x3_unit.sv
// Pipeline: a pixel is registered in the pixel stage (s1), then its result in
// the output register that drives edge_value_o once that register is free.
// Throughput: one pixel per cycle; the input only stalls while a finished
// result sits stalled in the output register and the pixel stage is full.
// Line stores are read/write RAMs with a registered read, read at pixel accept.
// Reset: counters, window, valid flags and column_gradient clear; line stores
// are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module prewitt_edge_filter_3x3_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pef3_pkg::pixel_t pixel_i,
  input  wire logic             frame_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pef3_pkg::pixel_t      edge_value_o,
  output logic                  frame_end_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             column_gradient_i
);

  import pef3_pkg::*;

  pixel_t upper_mem [IMAGE_SIZE];
  pixel_t middle_mem [IMAGE_SIZE];

  logic   col_grad_q;
  pos_t   col_q, row_q, col_d, row_d;
  pos_t   cur_col, cur_row;
  logic   in_acc;

  logic   s1_valid_q, s1_valid_d;
  pixel_t s1_px_q;
  pos_t   s1_col_q, s1_row_q;
  pixel_t top_rd_q, mid_rd_q;
  logic   s1_adv;

  pixel_t win_q [6];

  logic   out_valid_q, out_valid_d;
  pixel_t edge_q;
  logic   frame_end_q;

  logic   produce;
  sum_t   sum_a, sum_b, mag;
  logic   [SUM_W:0] diff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_grad_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      col_grad_q <= column_gradient_i;
    end
  end

  // pixel position, frame_start forces (0, 0)
  always_comb begin
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    if (cur_col == POS_LAST) begin
      col_d = '0;
      row_d = (cur_row == POS_LAST) ? '0 : cur_row + pos_t'(1);
    end else begin
      col_d = cur_col + pos_t'(1);
      row_d = cur_row;
    end
  end

  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q  <= pixel_i;
      s1_col_q <= cur_col;
      s1_row_q <= cur_row;
    end
  end

  // The write of one pixel and the read for the next never share an address
  // in a way a result can see: rows 0 and 1 of a column are always rewritten
  // before that column feeds a result.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      upper_mem[s1_col_q] <= mid_rd_q;
    end
    if (in_acc) begin
      top_rd_q <= upper_mem[cur_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      middle_mem[s1_col_q] <= s1_px_q;
    end
    if (in_acc) begin
      mid_rd_q <= middle_mem[cur_col];
    end
  end

  // window: [0..2] = column c-2 top/mid/bottom, [3..5] = column c-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd_q;
      win_q[4] <= mid_rd_q;
      win_q[5] <= s1_px_q;
    end
  end

  always_comb begin
    if (col_grad_q) begin
      sum_a = sum_t'(win_q[0]) + sum_t'(win_q[1]) + sum_t'(win_q[2]);
      sum_b = sum_t'(top_rd_q) + sum_t'(mid_rd_q) + sum_t'(s1_px_q);
    end else begin
      sum_a = sum_t'(win_q[0]) + sum_t'(win_q[3]) + sum_t'(top_rd_q);
      sum_b = sum_t'(win_q[2]) + sum_t'(win_q[5]) + sum_t'(s1_px_q);
    end
    diff    = {1'b0, sum_a} - {1'b0, sum_b};
    mag     = diff[SUM_W] ? sum_t'(-diff) : diff[SUM_W-1:0];
    produce = (s1_row_q >= pos_t'(2)) && (s1_col_q >= pos_t'(2));
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = produce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && produce) begin
      edge_q      <= div3(mag);
      frame_end_q <= (s1_row_q == POS_LAST) && (s1_col_q == POS_LAST);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;
  assign frame_end_o  = frame_end_q;

endmodule

`default_nettype wire

// File: hdl/pef3_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pef3_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire pef3_pkg::pixel_t edge_value_o,
  input wire logic             frame_end_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_value_o)
      && $stable(frame_end_o))
    else $error("stalled result changed");

  // a result only leaves through a transfer
  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // the input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  a_stall_keeps_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && in_valid_i |=> out_valid_o)
    else $error("result lost during input stall");

endmodule

bind prewitt_edge_filter_3x3_unit pef3_checker u_pef3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .edge_value_o (edge_value_o),
  .frame_end_o  (frame_end_o)
);

`default_nettype wire

// File: bench/prewitt_edge_filter_3x3_unit_tb.sv
`timescale 1ns / 1ps

module prewitt_edge_filter_3x3_unit_tb;
  import pef3_pkg::*;

  localparam int unsigned IDLE_PCT      = 26;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned RANDOM_ITEMS  = 320;
  localparam int unsigned RESTART_ITEMS = 100;
  localparam int unsigned STRAY_ODDS    = 25;
  localparam int unsigned QUIET_START   = 500;
  localparam int unsigned QUIET_END     = 1000;
  localparam int unsigned MAX_PRINTED   = 40;
  localparam pixel_t      PIX_MAX       = '1;
  localparam pixel_t      PIX_MIN       = '0;

  typedef enum logic [2:0] {
    PAT_RANDOM,
    PAT_ROW_BANDS,
    PAT_COL_BANDS,
    PAT_EXTREME,
    PAT_DIM,
    PAT_MIXED
  } pix_pattern_e;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_start;
  } pixel_xfer_t;

  typedef struct packed {
    pixel_t edge_value;
    logic   frame_end;
  } edge_result_t;

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   in_valid        = 1'b0;
  logic   in_stall;
  pixel_t pixel           = '0;
  logic   frame_start     = 1'b0;
  logic   out_valid;
  logic   out_stall       = 1'b0;
  pixel_t edge_value;
  logic   frame_end;
  logic   cfg_valid       = 1'b0;
  logic   cfg_ready;
  logic   column_gradient = 1'b0;

  pixel_xfer_t  pending_pixels[$];
  edge_result_t expected_edges[$];
  pixel_xfer_t  pixel_on_bus;

  // filter state as the testbench sees it
  pixel_t      upper_line [IMAGE_SIZE];
  pixel_t      middle_line[IMAGE_SIZE];
  pixel_t      win_cols[6];
  int unsigned col_pos;
  int unsigned row_pos;
  logic        col_grad_mode;

  int unsigned cycle_cnt  = 0;
  int unsigned mismatches = 0;
  logic        quiet;

  prewitt_edge_filter_3x3_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pixel_i           (pixel),
    .frame_start_i     (frame_start),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .edge_value_o      (edge_value),
    .frame_end_o       (frame_end),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .column_gradient_i (column_gradient)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // one long stretch where neither side idles
  assign quiet = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_END);

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t: %s", $time, msg);
  endtask

  function automatic void predict_edge(input pixel_xfer_t xfer);
    int unsigned  c;
    int unsigned  r;
    pixel_t       top;
    pixel_t       mid;
    int           sum;
    int           mag;
    edge_result_t res;
    if (xfer.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c   = col_pos;
    r   = row_pos;
    top = upper_line[c];
    mid = middle_line[c];
    if (r >= 2 && c >= 2) begin
      if (col_grad_mode) begin
        sum = int'(win_cols[0]) + int'(win_cols[1]) + int'(win_cols[2])
            - int'(top) - int'(mid) - int'(xfer.pixel);
      end else begin
        sum = int'(win_cols[0]) + int'(win_cols[3]) + int'(top)
            - int'(win_cols[2]) - int'(win_cols[5]) - int'(xfer.pixel);
      end
      mag            = (sum < 0) ? -sum : sum;
      res.edge_value = pixel_t'(mag / 3);
      res.frame_end  = (r == IMAGE_SIZE - 1) && (c == IMAGE_SIZE - 1);
      expected_edges.push_back(res);
    end
    // window moves one column left; new column is (top, mid, pixel)
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = xfer.pixel;
    upper_line[c]  = mid;
    middle_line[c] = xfer.pixel;
    if (c + 1 >= IMAGE_SIZE) begin
      col_pos = 0;
      row_pos = (r + 1 >= IMAGE_SIZE) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  initial begin
    for (int i = 0; i < IMAGE_SIZE; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    col_pos       = 0;
    row_pos       = 0;
    col_grad_mode = 1'b0;
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_edge(pixel_on_bus);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          pixel_on_bus = pending_pixels.pop_front();
          in_valid    <= 1'b1;
          pixel       <= pixel_on_bus.pixel;
          frame_start <= pixel_on_bus.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n) begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("edge_value %0d frame_end %0b with no result pending",
                                    edge_value, frame_end));
        end else begin
          want = expected_edges.pop_front();
          if (edge_value !== want.edge_value)
            report_mismatch($sformatf("edge_value %0d, expected %0d",
                                      edge_value, want.edge_value));
          if (frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, expected %0b",
                                      frame_end, want.frame_end));
        end
      end
    end
  end

  task automatic write_column_gradient(input logic value);
    cfg_valid       <= 1'b1;
    column_gradient <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    col_grad_mode = value;
    cfg_valid    <= 1'b0;
  endtask

  task automatic queue_segment(input logic with_start, input int unsigned count,
                               input pix_pattern_e pattern, input int unsigned stray_odds);
    pix_pattern_e row_pat;
    pixel_xfer_t  xfer;
    int unsigned  r;
    int unsigned  c;
    row_pat = pattern;
    for (int unsigned i = 0; i < count; i++) begin
      r = (i / IMAGE_SIZE) % IMAGE_SIZE;
      c = i % IMAGE_SIZE;
      if (pattern == PAT_MIXED && c == 0) row_pat = pix_pattern_e'($urandom_range(0, 4));
      case (row_pat)
        PAT_ROW_BANDS: xfer.pixel = (r % 4 < 2) ? PIX_MAX : PIX_MIN;
        PAT_COL_BANDS: xfer.pixel = (c % 4 < 2) ? PIX_MAX : PIX_MIN;
        PAT_EXTREME:   xfer.pixel = ($urandom_range(0, 1) != 0) ? PIX_MAX : PIX_MIN;
        PAT_DIM:       xfer.pixel = pixel_t'($urandom_range(0, 3));
        default:       xfer.pixel = pixel_t'($urandom_range(0, 255));
      endcase
      xfer.frame_start = (i == 0 && with_start)
                      || (stray_odds != 0 && $urandom_range(1, stray_odds) == 1);
      pending_pixels.push_back(xfer);
    end
  endtask

  // checked at the falling edge, after the driver and monitor have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_items;
    int unsigned seg_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // row bands: top and bottom rows always opposite, full-scale magnitude
    write_column_gradient(1'b0);
    queue_segment(1'b1, 2 * IMAGE_SIZE + 40, PAT_ROW_BANDS, 0);
    drain();

    // same frame goes on with column bands in the other direction
    write_column_gradient(1'b1);
    queue_segment(1'b0, 120, PAT_COL_BANDS, 0);
    drain();

    // still the same frame, direction picked per segment
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      write_column_gradient(1'($urandom_range(0, 1)));
      seg_len = $urandom_range(20, 80);
      queue_segment(1'b0, seg_len, PAT_MIXED, 0);
      random_items += seg_len;
      drain();
    end

    // abandoned frame: back-to-back frame_start, then stray restarts
    write_column_gradient(1'($urandom_range(0, 1)));
    queue_segment(1'b1, 1, PAT_EXTREME, 0);
    queue_segment(1'b1, 1, PAT_EXTREME, 0);
    queue_segment(1'b1, RESTART_ITEMS, PAT_MIXED, STRAY_ODDS);
    drain();

    if (mismatches == 0) begin
      $display("prewitt_edge_filter_3x3_unit: match");
    end else begin
      $display("prewitt_edge_filter_3x3_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("prewitt_edge_filter_3x3_unit: mismatch");
    $finish;
  end

endmodule
